>>> rtl/kce_pkg.sv
// Shared types, constants and command/status structures for the k-means engine.
package kce_pkg;

  localparam int unsigned MaxPoints   = 1024;
  localparam int unsigned PtIdxW      = 10;
  localparam int unsigned CountW      = 11;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned FixW        = 24;
  localparam int unsigned SumW        = 26;
  localparam int unsigned NumClusters = 4;
  localparam int unsigned ClIdxW      = 2;

  // Configuration register indexes
  localparam logic [2:0] RegIter  = 3'd0;
  localparam logic [2:0] RegClus  = 3'd1;
  localparam logic [2:0] RegSeedA = 3'd2;
  localparam logic [2:0] RegSeedB = 3'd3;
  localparam logic [2:0] RegSeedC = 3'd4;
  localparam logic [2:0] RegSeedD = 3'd5;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic KindCentroid = 1'b0;
  localparam logic KindLabel    = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StReadWait,
    StSeedRd,
    StSeedWr,
    StClear,
    StAssign,
    StDrain,
    StDivStart,
    StDivRun,
    StDivNext,
    StReport,
    StLabelOut
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                store_pt;
    logic                new_set;
    logic                mem_rd;
    logic [PtIdxW-1:0]   rd_addr;
    logic                seed_wr;
    logic [ClIdxW-1:0]   clus;
    logic                clr_acc;
    logic                assign_en;
    logic                div_start;
    logic                div_wr;
    logic                lbl_rd;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CountW-1:0]   loaded;
    logic                div_busy;
  } stat_t;

endpackage

>>> rtl/kmeans_cluster_engine.sv
// Top level of the k-means clustering engine.
// Load transactions each store a point into a 1024-entry memory. A load with tlast runs
// Lloyd k-means: seeding reads the seed point of each cluster, each round makes an
// assignment pass through the point memory read port, then computes each centroid
// coordinate in the shared bit-serial divider, and after the last round the centroid
// transactions appear. A label read passes through a wait state, where the label memory
// is read, before its result is shown. One input is handled at a time.
module kmeans_cluster_engine import kce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // coord_x[15:0], coord_y[31:16], point_index[41:32]
  input  logic        s_axis_tuser,  // opcode
  input  logic        s_axis_tlast,  // final_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // cluster_index[1:0], centroid_x[25:2], centroid_y[49:26]
  output logic [1:0]  m_axis_tuser,  // result_kind[0], overflow_flag[1]
  output logic        m_axis_tlast,  // last_result
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  logic [7:0]          iter_q;
  logic [2:0]          clus_q;
  logic [4*PtIdxW-1:0] seeds_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q  <= 8'd40;
      clus_q  <= 3'd3;
      seeds_q <= {10'd3, 10'd2, 10'd1, 10'd0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegIter:  iter_q <= cfg_data_i[7:0];
        RegClus:  clus_q <= cfg_data_i[2:0];
        RegSeedA: seeds_q[0*PtIdxW +: PtIdxW] <= cfg_data_i;
        RegSeedB: seeds_q[1*PtIdxW +: PtIdxW] <= cfg_data_i;
        RegSeedC: seeds_q[2*PtIdxW +: PtIdxW] <= cfg_data_i;
        RegSeedD: seeds_q[3*PtIdxW +: PtIdxW] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmd_t  cmd;
  stat_t stat;
  logic  in_fire, kind, ovf;
  logic [FixW-1:0]   cx, cy;
  logic [ClIdxW-1:0] lbl;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  kce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .op_i        (s_axis_tuser),
    .fin_i       (s_axis_tlast),
    .pidx_i      (s_axis_tdata[41:32]),
    .out_ready_i (m_axis_tready),
    .iter_i      (iter_q),
    .nclus_i     (clus_q),
    .seeds_i     (seeds_q),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (kind),
    .out_last_o  (m_axis_tlast)
  );

  kce_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .coord_x_i  (s_axis_tdata[15:0]),
    .coord_y_i  (s_axis_tdata[31:16]),
    .nclus_i    (clus_q == 3'd0 ? 3'd1 : (clus_q > 3'd4 ? 3'd4 : clus_q)),
    .stat_o     (stat),
    .overflow_o (ovf),
    .cen_x_o    (cx),
    .cen_y_o    (cy),
    .label_o    (lbl)
  );

  // Result formatting
  always_comb begin
    m_axis_tdata = '0;
    if (kind == KindLabel) begin
      m_axis_tdata[1:0] = lbl;
    end else begin
      m_axis_tdata[1:0]   = cmd.clus;
      m_axis_tdata[25:2]  = cx;
      m_axis_tdata[49:26] = cy;
    end
  end
  assign m_axis_tuser = {ovf, kind};

endmodule

>>> rtl/kce_divider.sv
// Restoring divider: 34-bit dividend by 11-bit divisor, one quotient bit a cycle.
module kce_divider import kce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SumW+7:0]   dividend_i,
  input  logic [CountW-1:0] divisor_i,
  output logic              busy_o,
  output logic [FixW-1:0]   quot_o
);

  localparam int unsigned DivW = SumW + 8;

  logic [DivW-1:0]   quo_q, quo_d;
  logic [CountW:0]   rem_q, rem_d;
  logic [CountW-1:0] den_q, den_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [CountW:0]   trial;

  // One shift-subtract step per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[CountW-1:0], quo_q[DivW-1]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = 6'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q[FixW-1:0];

endmodule

>>> rtl/kce_datapath.sv
// Point and label memories, centroids, distance pipeline, accumulators, divider.
module kce_datapath import kce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [CoordW-1:0] coord_x_i,
  input  logic [CoordW-1:0] coord_y_i,
  input  logic [2:0]        nclus_i,
  output stat_t             stat_o,
  output logic              overflow_o,
  output logic [FixW-1:0]   cen_x_o,
  output logic [FixW-1:0]   cen_y_o,
  output logic [ClIdxW-1:0] label_o
);

  logic [CoordW-1:0] px_mem [MaxPoints];
  logic [CoordW-1:0] py_mem [MaxPoints];
  logic [ClIdxW-1:0] lb_mem [MaxPoints];

  logic [CountW-1:0] loaded_q;
  logic              ovf_q;
  logic [FixW-1:0]   cx_q [NumClusters];
  logic [FixW-1:0]   cy_q [NumClusters];
  logic [SumW-1:0]   sx_q [NumClusters];
  logic [SumW-1:0]   sy_q [NumClusters];
  logic [CountW-1:0] mc_q [NumClusters];

  logic [CoordW-1:0] rdx_q, rdy_q;
  logic [ClIdxW-1:0] rdl_q;
  logic [PtIdxW-1:0] addr1_q, addr2_q;
  logic              v1_q, v2_q;

  logic [CountW-1:0] wr_ptr;
  logic              full;

  assign wr_ptr = cmd_i.new_set ? '0 : loaded_q;
  assign full   = (wr_ptr == CountW'(MaxPoints));

  // Load count and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      ovf_q    <= 1'b0;
    end else if (cmd_i.store_pt) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        loaded_q <= wr_ptr + CountW'(1);
        if (cmd_i.new_set) ovf_q <= 1'b0;
      end
    end
  end

  // Point memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_pt && !full) begin
      px_mem[wr_ptr[PtIdxW-1:0]] <= coord_x_i;
      py_mem[wr_ptr[PtIdxW-1:0]] <= coord_y_i;
    end
    if (cmd_i.mem_rd) begin
      rdx_q <= px_mem[cmd_i.rd_addr];
      rdy_q <= py_mem[cmd_i.rd_addr];
    end
  end

  // Distance stage 1: absolute differences per centroid
  logic [FixW-1:0] dx_q [NumClusters];
  logic [FixW-1:0] dy_q [NumClusters];
  logic [CoordW-1:0] s1x_q, s1y_q, s2x_q, s2y_q;
  logic [2*FixW:0]   d2_q [NumClusters];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumClusters; k++) begin
      logic [FixW-1:0] a, b;
      a = {rdx_q, 8'd0};
      b = {rdy_q, 8'd0};
      dx_q[k] <= (a >= cx_q[k]) ? a - cx_q[k] : cx_q[k] - a;
      dy_q[k] <= (b >= cy_q[k]) ? b - cy_q[k] : cy_q[k] - b;
    end
    s1x_q <= rdx_q;
    s1y_q <= rdy_q;
    // stage 2: squares and sum
    for (int k = 0; k < NumClusters; k++) begin
      d2_q[k] <= (2*FixW+1)'(dx_q[k] * dx_q[k]) + (2*FixW+1)'(dy_q[k] * dy_q[k]);
    end
    s2x_q <= s1x_q;
    s2y_q <= s1y_q;
  end

  // Valid and address travel with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      addr1_q <= '0;
      addr2_q <= '0;
    end else begin
      v1_q    <= cmd_i.assign_en;
      v2_q    <= v1_q;
      addr1_q <= cmd_i.rd_addr;
      addr2_q <= addr1_q;
    end
  end

  // Nearest centroid, lower index wins ties
  logic [ClIdxW-1:0] best;
  logic [2*FixW:0]   bd;
  always_comb begin
    best = '0;
    bd   = d2_q[0];
    for (int k = 1; k < NumClusters; k++) begin
      if (k < int'(nclus_i) && d2_q[k] < bd) begin
        bd   = d2_q[k];
        best = ClIdxW'(k);
      end
    end
  end

  // Labels: cleared on load, written in assignment, read for label reports
  // v3_q and addr3_q line up with d2_q, s2x_q and s2y_q
  logic v3_q;
  logic [PtIdxW-1:0] addr3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    addr3_q <= addr2_q;
    if (cmd_i.store_pt && !full) begin
      lb_mem[wr_ptr[PtIdxW-1:0]] <= '0;
    end else if (v3_q) begin
      lb_mem[addr3_q] <= best;
    end
    if (cmd_i.lbl_rd) rdl_q <= lb_mem[cmd_i.rd_addr];
  end

  // Divider shared by all centroid coordinates
  logic              div_busy;
  logic [FixW-1:0]   quot;
  logic              sel_y_q;
  logic [SumW+7:0]   dividend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sel_y_q <= 1'b0;
    else if (cmd_i.div_wr) sel_y_q <= ~sel_y_q;
  end

  assign dividend = sel_y_q ? {sy_q[cmd_i.clus], 8'd0} : {sx_q[cmd_i.clus], 8'd0};

  kce_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (mc_q[cmd_i.clus]),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Centroids, sums and member counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumClusters; k++) begin
        cx_q[k] <= '0;
        cy_q[k] <= '0;
        sx_q[k] <= '0;
        sy_q[k] <= '0;
        mc_q[k] <= '0;
      end
    end else begin
      if (cmd_i.seed_wr) begin
        cx_q[cmd_i.clus] <= {rdx_q, 8'd0};
        cy_q[cmd_i.clus] <= {rdy_q, 8'd0};
      end
      if (cmd_i.clr_acc) begin
        for (int k = 0; k < NumClusters; k++) begin
          sx_q[k] <= '0;
          sy_q[k] <= '0;
          mc_q[k] <= '0;
        end
      end else if (v3_q) begin
        sx_q[best] <= sx_q[best] + SumW'(s2x_q);
        sy_q[best] <= sy_q[best] + SumW'(s2y_q);
        mc_q[best] <= mc_q[best] + CountW'(1);
      end
      if (cmd_i.div_wr && mc_q[cmd_i.clus] != '0) begin
        if (sel_y_q) cy_q[cmd_i.clus] <= quot;
        else         cx_q[cmd_i.clus] <= quot;
      end
    end
  end

  assign stat_o.loaded   = loaded_q;
  assign stat_o.div_busy = div_busy;
  assign overflow_o      = ovf_q;
  assign cen_x_o         = cx_q[cmd_i.clus];
  assign cen_y_o         = cy_q[cmd_i.clus];
  assign label_o         = rdl_q;

endmodule

>>> rtl/kce_ctrl.sv
// Sequencer: load, seeding, assignment passes, centroid update and reporting.
module kce_ctrl import kce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              op_i,
  input  logic              fin_i,
  input  logic [PtIdxW-1:0] pidx_i,
  input  logic              out_ready_i,
  input  logic [7:0]        iter_i,
  input  logic [2:0]        nclus_i,
  input  logic [4*PtIdxW-1:0] seeds_i,
  input  stat_t             stat_i,
  output cmd_t              cmd_o,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output logic              out_kind_o,
  output logic              out_last_o
);

  state_e state_q, state_d;
  logic              closed_q, closed_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [ClIdxW-1:0] k_q, k_d;
  logic [7:0]        rnd_q, rnd_d;
  logic [2:0]        nclus_q, nclus_d;
  logic [PtIdxW-1:0] ridx_q, ridx_d;
  logic [2:0]        dly_q, dly_d;
  logic              half_q, half_d;

  logic [PtIdxW-1:0] seed;
  logic [CountW-1:0] n;

  assign n    = stat_i.loaded;
  always_comb begin
    seed = seeds_i[k_q*PtIdxW +: PtIdxW];
    if ({1'b0, seed} >= n) seed = PtIdxW'(n - CountW'(1));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    closed_d = closed_q;
    idx_d = idx_q;
    k_d = k_q;
    rnd_d = rnd_q;
    nclus_d = nclus_q;
    ridx_d = ridx_q;
    dly_d = dly_q;
    half_d = half_q;
    case (state_q)
      StIdle: begin
        if (in_fire_i) begin
          if (op_i == OpRead) begin
            ridx_d  = pidx_i;
            state_d = StReadWait;
          end else begin
            closed_d = 1'b0;
            if (fin_i) begin
              nclus_d = (nclus_i == 3'd0) ? 3'd1 : (nclus_i > 3'd4) ? 3'd4 : nclus_i;
              rnd_d   = (iter_i == 8'd0) ? 8'd1 : iter_i;
              k_d     = '0;
              state_d = StSeedRd;
            end
          end
        end
      end
      StReadWait: state_d = StLabelOut;
      StLabelOut: if (out_ready_i) state_d = StIdle;
      StSeedRd: state_d = StSeedWr;
      StSeedWr: begin
        if ({1'b0, k_q} == nclus_q - 3'd1) begin
          state_d = StClear;
        end else begin
          k_d = k_q + ClIdxW'(1);
          state_d = StSeedRd;
        end
      end
      StClear: begin
        idx_d = '0;
        state_d = StAssign;
      end
      StAssign: begin
        idx_d = idx_q + CountW'(1);
        if (idx_q == n - CountW'(1)) begin
          dly_d = 3'd4;
          state_d = StDrain;
        end
      end
      StDrain: begin
        dly_d = dly_q - 3'd1;
        if (dly_q == 3'd1) begin
          k_d = '0;
          half_d = 1'b0;
          state_d = StDivStart;
        end
      end
      StDivStart: state_d = StDivRun;
      StDivRun: if (!stat_i.div_busy) state_d = StDivNext;
      StDivNext: begin
        half_d = ~half_q;
        if (!half_q) begin
          state_d = StDivStart;
        end else if ({1'b0, k_q} == nclus_q - 3'd1) begin
          rnd_d = rnd_q - 8'd1;
          k_d = '0;
          state_d = (rnd_q == 8'd1) ? StReport : StClear;
        end else begin
          k_d = k_q + ClIdxW'(1);
          state_d = StDivStart;
        end
      end
      StReport: begin
        if (out_ready_i) begin
          if ({1'b0, k_q} == nclus_q - 3'd1) begin
            closed_d = 1'b1;
            state_d = StIdle;
          end else begin
            k_d = k_q + ClIdxW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    out_kind_o = KindCentroid;
    out_last_o = 1'b0;
    cmd_o.clus = k_q;
    cmd_o.rd_addr = idx_q[PtIdxW-1:0];
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.rd_addr = pidx_i;
        cmd_o.store_pt = in_fire_i && (op_i == OpLoad);
        cmd_o.new_set = closed_q;
      end
      StReadWait: begin
        cmd_o.rd_addr = ridx_q;
        cmd_o.lbl_rd = 1'b1;
      end
      StLabelOut: begin
        out_valid_o = 1'b1;
        out_kind_o = KindLabel;
        out_last_o = 1'b1;
      end
      StSeedRd: begin
        cmd_o.rd_addr = seed;
        cmd_o.mem_rd = 1'b1;
      end
      StSeedWr: cmd_o.seed_wr = 1'b1;
      StClear: cmd_o.clr_acc = 1'b1;
      StAssign: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.assign_en = 1'b1;
      end
      StDivStart: cmd_o.div_start = 1'b1;
      StDivNext: cmd_o.div_wr = 1'b1;
      StReport: begin
        out_valid_o = 1'b1;
        out_last_o = ({1'b0, k_q} == nclus_q - 3'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      closed_q <= 1'b0;
      idx_q <= '0;
      k_q <= '0;
      rnd_q <= '0;
      nclus_q <= 3'd1;
      ridx_q <= '0;
      dly_q <= '0;
      half_q <= 1'b0;
    end else begin
      state_q <= state_d;
      closed_q <= closed_d;
      idx_q <= idx_d;
      k_q <= k_d;
      rnd_q <= rnd_d;
      nclus_q <= nclus_d;
      ridx_q <= ridx_d;
      dly_q <= dly_d;
      half_q <= half_d;
    end
  end

  // Assertions
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nclus_q >= 3'd1 && nclus_q <= 3'd4) else $error("cluster count out of range");
  a_assign_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StAssign |-> idx_q < n) else $error("assign index past loaded count");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("accepting while result pending");

endmodule
